@@ hdl/kbs_pkg.sv @@
// kbs_pkg: shared constants, types and elaboration-time helpers for the
// kinematic bicycle step pipeline (cordic table, gain, reciprocals).
// no dependencies.
package kbs_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int ATAN_ENTRIES = 30;
  localparam int CW           = 34;   // cordic datapath width
  localparam int GAIN_W       = 30;
  localparam int MAG_W        = 31;
  localparam int NUM_W        = 29;   // heading divider dividend width
  localparam int WB_W         = 13;

  localparam logic [WB_W-1:0] WB_RESET = 13'd691;
  localparam logic [WB_W-1:0] WB_MIN   = 13'd64;

  localparam logic signed [14:0] STEER_LIMIT = 15'sd9830;

  localparam logic signed [35:0] PI_Q30      = 36'sd3373259426;
  localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [35:0] TWO_PI_Q30  = 36'sd6746518852;

  localparam logic signed [31:0] PI_Q13     = 32'sd25736;
  localparam logic signed [31:0] TWO_PI_Q13 = 32'sd51472;
  localparam logic [24:0] HD_RECIP = 25'((64'sd1 <<< 40) / 51472);

  localparam logic signed [31:0] ATAN_Q30 [ATAN_ENTRIES] = '{
    32'sd843314856, 32'sd497837829, 32'sd263043836, 32'sd133525158, 32'sd67021686,
    32'sd33543515,  32'sd16775850,  32'sd8388437,   32'sd4194282,   32'sd2097149,
    32'sd1048575,   32'sd524287,    32'sd262143,    32'sd131071,    32'sd65535,
    32'sd32767,     32'sd16383,     32'sd8191,      32'sd4095,      32'sd2047,
    32'sd1023,      32'sd511,       32'sd255,       32'sd127,       32'sd63,
    32'sd31,        32'sd15,        32'sd7,         32'sd3,         32'sd1
  };

  typedef enum logic {
    CM_ROTATE,
    CM_VECTOR
  } cordic_mode_t;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [15:0] hd;
    logic signed [15:0] v;
    logic signed [31:0] vdt;
  } item_t;

  // x output of a zero-angle rotation of (2^29, 0)
  function automatic longint cordic_gain();
    longint x;
    longint y;
    longint z;
    longint xn;
    x = 64'sd536870912;
    y = 64'sd0;
    z = 64'sd0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (z >= 0) begin
        xn = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - longint'(ATAN_Q30[i]);
      end else begin
        xn = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + longint'(ATAN_Q30[i]);
      end
      x = xn;
    end
    return x;
  endfunction

  localparam longint GAIN = cordic_gain();
  localparam logic [GAIN_W-1:0] GAIN_Q = GAIN_W'(GAIN);
  localparam longint GAIN_RECIP_L = (64'sd1 <<< 61) / GAIN;
  localparam logic [31:0] GAIN_RECIP = 32'(GAIN_RECIP_L);

endpackage

@@ hdl/kbs_cordic.sv @@
// kbs_cordic: fully pipelined cordic, one iteration per register stage,
// rotation or vectoring selected by a mode input. uses kbs_pkg.
module kbs_cordic (
  input  logic                             clk,
  input  logic                             en,
  input  kbs_pkg::cordic_mode_t            mode,
  input  logic signed [kbs_pkg::CW-1:0]    x_in,
  input  logic signed [kbs_pkg::CW-1:0]    y_in,
  input  logic signed [kbs_pkg::CW-1:0]    z_in,
  output logic signed [kbs_pkg::CW-1:0]    x_out,
  output logic signed [kbs_pkg::CW-1:0]    y_out,
  output logic signed [kbs_pkg::CW-1:0]    z_out
);

  localparam int N  = kbs_pkg::CORDIC_STEPS;
  localparam int CW = kbs_pkg::CW;

  logic signed [CW-1:0] x_r   [N];
  logic signed [CW-1:0] y_r   [N];
  logic signed [CW-1:0] z_r   [N];
  logic signed [CW-1:0] x_p   [N];
  logic signed [CW-1:0] y_p   [N];
  logic signed [CW-1:0] z_p   [N];
  logic signed [CW-1:0] x_nxt [N];
  logic signed [CW-1:0] y_nxt [N];
  logic signed [CW-1:0] z_nxt [N];
  logic [N-1:0]         ccw;

  always_comb begin
    x_p[0] = x_in;
    y_p[0] = y_in;
    z_p[0] = z_in;
    for (int i = 1; i < N; i++) begin
      x_p[i] = x_r[i-1];
      y_p[i] = y_r[i-1];
      z_p[i] = z_r[i-1];
    end
    for (int i = 0; i < N; i++) begin
      // rotation follows the sign of z, vectoring drives y to zero
      ccw[i] = (mode == kbs_pkg::CM_ROTATE) ? !z_p[i][CW-1] : z_p[i][CW-1] ^ z_p[i][CW-1]
               ^ y_p[i][CW-1];
      if (ccw[i]) begin
        x_nxt[i] = x_p[i] - (y_p[i] >>> i);
        y_nxt[i] = y_p[i] + (x_p[i] >>> i);
        z_nxt[i] = z_p[i] - CW'(kbs_pkg::ATAN_Q30[i]);
      end else begin
        x_nxt[i] = x_p[i] + (y_p[i] >>> i);
        y_nxt[i] = y_p[i] - (x_p[i] >>> i);
        z_nxt[i] = z_p[i] + CW'(kbs_pkg::ATAN_Q30[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < N; i++) begin
        x_r[i] <= x_nxt[i];
        y_r[i] <= y_nxt[i];
        z_r[i] <= z_nxt[i];
      end
    end
  end

  assign x_out = x_r[N-1];
  assign y_out = y_r[N-1];
  assign z_out = z_r[N-1];

endmodule

@@ hdl/kbs_gdiv.sv @@
// kbs_gdiv: three-stage divide of a cordic output by the cordic gain,
// q = trunc(val * 2^30 / gain), optional sign flip. uses kbs_pkg.
module kbs_gdiv (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [kbs_pkg::CW-1:0] val_in,
  input  logic                          neg_in,
  output logic signed [31:0]            q_out
);

  localparam int MAG_W = kbs_pkg::MAG_W;

  logic signed [kbs_pkg::CW-1:0] val_abs;
  logic [MAG_W-1:0] mag1_r;
  logic [MAG_W-1:0] mag2_r;
  logic             sgn1_r;
  logic             sgn2_r;
  logic [62:0]      p1_r;
  logic [31:0]      q0;
  logic [31:0]      q0_2_r;
  logic [61:0]      qg2_r;
  logic [61:0]      rem;
  logic [31:0]      q;
  logic signed [31:0] q_r;

  assign val_abs = val_in[kbs_pkg::CW-1] ? -val_in : val_in;
  assign q0      = p1_r[62:31];

  // estimate is at most one low, one compare fixes it
  assign rem = {1'b0, mag2_r, 30'b0} - qg2_r;
  assign q   = q0_2_r + 32'(rem >= {32'b0, kbs_pkg::GAIN_Q});

  always_ff @(posedge clk) begin
    if (en) begin
      mag1_r <= val_abs[MAG_W-1:0];
      sgn1_r <= val_in[kbs_pkg::CW-1] ^ neg_in;
      p1_r   <= 63'(val_abs[MAG_W-1:0]) * 63'(kbs_pkg::GAIN_RECIP);
      mag2_r <= mag1_r;
      sgn2_r <= sgn1_r;
      q0_2_r <= q0;
      qg2_r  <= 62'(q0) * 62'(kbs_pkg::GAIN_Q);
      q_r    <= sgn2_r ? -$signed(q) : $signed(q);
    end
  end

  assign q_out = q_r;

endmodule

@@ hdl/kinematic_bicycle_step_core.sv @@
// kinematic_bicycle_step_core: pipelined kinematic bicycle pose update.
// built from four cordic pipelines, the gain dividers and a 29-stage
// restoring divider for the heading rate; one item per cycle sustained
// while the output is not stalled. a stalled output holds the whole
// pipeline. synchronous active-low reset clears the valid bits and
// loads the wheelbase register with 691.
module kinematic_bicycle_step_core (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // pos_x[31:0] pos_y[63:32] heading[79:64] speed_cmd[95:80]
  // steer_cmd[110:96] time_step[126:111] zero[127]
  input  logic [127:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // new_x[31:0] new_y[63:32] new_heading[79:64] new_speed[95:80]
  output logic [95:0]  out_tdata,
  input  logic         cfg_wr_en,
  input  logic [12:0]  cfg_wr_data
);

  localparam int L     = kbs_pkg::CORDIC_STEPS;
  localparam int CW    = kbs_pkg::CW;
  localparam int NUM_W = kbs_pkg::NUM_W;
  localparam int WB_W  = kbs_pkg::WB_W;
  localparam int S_GA  = L + 3;
  localparam int S_V   = 2*L + 3;
  localparam int S_M1  = 3*L + 10;
  localparam int S_M2  = S_M1 + 1;
  localparam int S_M3  = S_M2 + 1;
  localparam int S_DV  = S_M2 + NUM_W;
  localparam int LAST  = S_DV + 4;

  logic [WB_W-1:0] wb_r;
  logic [WB_W-1:0] wbc;
  logic [LAST:0]   vld_r;
  logic            en;

  kbs_pkg::item_t itm_in;
  kbs_pkg::item_t itm_r [LAST+1];

  logic signed [14:0]    steer;
  logic signed [14:0]    steer_c;
  logic signed [CW-1:0]  z0_r;

  always_comb begin
    en = !vld_r[LAST] || out_tready;
    wbc = (wb_r < kbs_pkg::WB_MIN) ? kbs_pkg::WB_MIN : wb_r;
    steer = $signed(in_tdata[110:96]);
    if (steer > kbs_pkg::STEER_LIMIT) begin
      steer_c = kbs_pkg::STEER_LIMIT;
    end else if (steer < -kbs_pkg::STEER_LIMIT) begin
      steer_c = -kbs_pkg::STEER_LIMIT;
    end else begin
      steer_c = steer;
    end
    itm_in.px  = $signed(in_tdata[31:0]);
    itm_in.py  = $signed(in_tdata[63:32]);
    itm_in.hd  = $signed(in_tdata[79:64]);
    itm_in.v   = $signed(in_tdata[95:80]);
    itm_in.vdt = $signed(in_tdata[95:80]) * $signed({1'b0, in_tdata[126:111]});
  end

  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wb_r  <= kbs_pkg::WB_RESET;
      vld_r <= '0;
    end else begin
      if (cfg_wr_en) begin
        wb_r <= cfg_wr_data;
      end
      if (en) begin
        vld_r <= {vld_r[LAST-1:0], in_tvalid};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      itm_r[0] <= itm_in;
      for (int k = 1; k <= LAST; k++) begin
        itm_r[k] <= itm_r[k-1];
      end
      z0_r <= CW'(steer_c) <<< 17;
    end
  end

  // sin and cos of the steering angle
  logic signed [CW-1:0] ax;
  logic signed [CW-1:0] ay;
  logic signed [31:0]   cs;
  logic signed [31:0]   ss;

  kbs_cordic u_cordic_steer (
    .clk   (clk),
    .en    (en),
    .mode  (kbs_pkg::CM_ROTATE),
    .x_in  (CW'(64'sd536870912)),
    .y_in  ('0),
    .z_in  (z0_r),
    .x_out (ax),
    .y_out (ay),
    .z_out ()
  );

  kbs_gdiv u_gdiv_cs (.clk(clk), .en(en), .val_in(ax), .neg_in(1'b0), .q_out(cs));
  kbs_gdiv u_gdiv_ss (.clk(clk), .en(en), .val_in(ay), .neg_in(1'b0), .q_out(ss));

  // slip angle beta = atan2(sin/2, cos)
  logic signed [CW-1:0] beta;

  kbs_cordic u_cordic_beta (
    .clk   (clk),
    .en    (en),
    .mode  (kbs_pkg::CM_VECTOR),
    .x_in  (CW'(cs)),
    .y_in  (CW'(ss >>> 1)),
    .z_in  ('0),
    .x_out (),
    .y_out (),
    .z_out (beta)
  );

  // heading + beta, reduced into (-pi, pi] then folded into [-pi/2, pi/2]
  logic signed [35:0]   th;
  logic signed [35:0]   u1_r;
  logic signed [35:0]   m2_r;
  logic signed [35:0]   t3;
  logic signed [CW-1:0] beta1_r;
  logic signed [CW-1:0] beta2_r;
  logic signed [CW-1:0] beta3_r;
  logic signed [CW-1:0] tf3_r;
  logic                 flip3_r;
  logic [L-1:0]         flp_r;

  assign th = (36'(itm_r[S_V].hd) <<< 17) + 36'(beta);
  assign t3 = kbs_pkg::PI_Q30 - m2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      u1_r    <= kbs_pkg::PI_Q30 - th;
      beta1_r <= beta;
      if (u1_r < 0) begin
        m2_r <= u1_r + kbs_pkg::TWO_PI_Q30;
      end else if (u1_r >= kbs_pkg::TWO_PI_Q30) begin
        m2_r <= u1_r - kbs_pkg::TWO_PI_Q30;
      end else begin
        m2_r <= u1_r;
      end
      beta2_r <= beta1_r;
      if (t3 > kbs_pkg::HALF_PI_Q30) begin
        tf3_r   <= CW'(t3 - kbs_pkg::PI_Q30);
        flip3_r <= 1'b1;
      end else if (t3 < -kbs_pkg::HALF_PI_Q30) begin
        tf3_r   <= CW'(t3 + kbs_pkg::PI_Q30);
        flip3_r <= 1'b1;
      end else begin
        tf3_r   <= CW'(t3);
        flip3_r <= 1'b0;
      end
      beta3_r <= beta2_r;
      flp_r   <= {flp_r[L-2:0], flip3_r};
    end
  end

  logic signed [CW-1:0] by;
  logic signed [CW-1:0] cx;
  logic signed [CW-1:0] cy;
  logic signed [31:0]   sb;
  logic signed [31:0]   ct;
  logic signed [31:0]   stt;

  kbs_cordic u_cordic_sbeta (
    .clk   (clk),
    .en    (en),
    .mode  (kbs_pkg::CM_ROTATE),
    .x_in  (CW'(64'sd536870912)),
    .y_in  ('0),
    .z_in  (beta3_r),
    .x_out (),
    .y_out (by),
    .z_out ()
  );

  kbs_cordic u_cordic_theta (
    .clk   (clk),
    .en    (en),
    .mode  (kbs_pkg::CM_ROTATE),
    .x_in  (CW'(64'sd536870912)),
    .y_in  ('0),
    .z_in  (tf3_r),
    .x_out (cx),
    .y_out (cy),
    .z_out ()
  );

  kbs_gdiv u_gdiv_sb (.clk(clk), .en(en), .val_in(by), .neg_in(1'b0), .q_out(sb));
  kbs_gdiv u_gdiv_ct (.clk(clk), .en(en), .val_in(cx), .neg_in(flp_r[L-1]), .q_out(ct));
  kbs_gdiv u_gdiv_st (.clk(clk), .en(en), .val_in(cy), .neg_in(flp_r[L-1]), .q_out(stt));

  // products, rounding, saturation
  logic signed [63:0] pct_r;
  logic signed [63:0] pst_r;
  logic signed [63:0] psb_r;
  logic signed [63:0] pct_rnd;
  logic signed [63:0] pst_rnd;
  logic [63:0]        psb_mag;
  logic [63:0]        num_sum;
  logic signed [25:0] dx_r;
  logic signed [25:0] dy_r;
  logic [NUM_W-1:0]   num_r;
  logic               nsg_r;
  logic signed [32:0] sx;
  logic signed [32:0] sy;
  logic signed [31:0] nx_r [S_M3:LAST];
  logic signed [31:0] ny_r [S_M3:LAST];

  assign pct_rnd = pct_r + (64'sd1 <<< 37);
  assign pst_rnd = pst_r + (64'sd1 <<< 37);
  assign psb_mag = psb_r[63] ? 64'(-psb_r) : 64'(psb_r);
  assign num_sum = psb_mag + {19'b0, wbc, 32'b0};
  assign sx = 33'(itm_r[S_M2].px) + 33'(dx_r);
  assign sy = 33'(itm_r[S_M2].py) + 33'(dy_r);

  always_ff @(posedge clk) begin
    if (en) begin
      pct_r <= 64'(itm_r[S_M1-1].vdt) * 64'(ct);
      pst_r <= 64'(itm_r[S_M1-1].vdt) * 64'(stt);
      psb_r <= 64'(itm_r[S_M1-1].vdt) * 64'(sb);
      dx_r  <= 26'(pct_rnd >>> 38);
      dy_r  <= 26'(pst_rnd >>> 38);
      num_r <= num_sum[61:33];
      nsg_r <= psb_r[63];
      if (sx > 33'sd2147483647) begin
        nx_r[S_M3] <= 32'sh7fffffff;
      end else if (sx < -33'sd2147483648) begin
        nx_r[S_M3] <= 32'sh80000000;
      end else begin
        nx_r[S_M3] <= 32'(sx);
      end
      if (sy > 33'sd2147483647) begin
        ny_r[S_M3] <= 32'sh7fffffff;
      end else if (sy < -33'sd2147483648) begin
        ny_r[S_M3] <= 32'sh80000000;
      end else begin
        ny_r[S_M3] <= 32'(sy);
      end
      for (int k = S_M3 + 1; k <= LAST; k++) begin
        nx_r[k] <= nx_r[k-1];
        ny_r[k] <= ny_r[k-1];
      end
    end
  end

  // restoring divider by the wheelbase, one quotient bit per stage
  logic [WB_W-1:0]  rem_r   [NUM_W];
  logic [NUM_W-1:0] quo_r   [NUM_W];
  logic [NUM_W-1:0] nmd_r   [NUM_W];
  logic [NUM_W-1:0] dsg_r;
  logic [WB_W-1:0]  rem_p   [NUM_W];
  logic [NUM_W-1:0] quo_p   [NUM_W];
  logic [NUM_W-1:0] nmd_p   [NUM_W];
  logic [WB_W:0]    rem_sh  [NUM_W];
  logic [NUM_W-1:0] qbit;
  logic [WB_W-1:0]  rem_nxt [NUM_W];
  logic [NUM_W-1:0] quo_nxt [NUM_W];

  always_comb begin
    rem_p[0] = '0;
    quo_p[0] = '0;
    nmd_p[0] = num_r;
    for (int j = 1; j < NUM_W; j++) begin
      rem_p[j] = rem_r[j-1];
      quo_p[j] = quo_r[j-1];
      nmd_p[j] = nmd_r[j-1];
    end
    for (int j = 0; j < NUM_W; j++) begin
      rem_sh[j]  = {rem_p[j], nmd_p[j][NUM_W-1-j]};
      qbit[j]    = rem_sh[j] >= {1'b0, wbc};
      rem_nxt[j] = qbit[j] ? WB_W'(rem_sh[j] - {1'b0, wbc}) : WB_W'(rem_sh[j]);
      quo_nxt[j] = {quo_p[j][NUM_W-2:0], qbit[j]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < NUM_W; j++) begin
        rem_r[j] <= rem_nxt[j];
        quo_r[j] <= quo_nxt[j];
        nmd_r[j] <= nmd_p[j];
      end
      dsg_r <= {dsg_r[NUM_W-2:0], nsg_r};
    end
  end

  // heading update and wrap into (-pi, pi]
  logic signed [31:0] dh;
  logic signed [31:0] hu1_r;
  logic signed [31:0] hu2_r;
  logic signed [57:0] hp2_r;
  logic signed [17:0] hq0;
  logic signed [31:0] hm3_r;
  logic signed [31:0] hm;
  logic signed [15:0] hd4_r;

  assign dh  = dsg_r[NUM_W-1] ? -$signed(32'(quo_r[NUM_W-1]))
                              : $signed(32'(quo_r[NUM_W-1]));
  assign hq0 = 18'(hp2_r >>> 40);

  always_comb begin
    if (hm3_r < 0) begin
      hm = hm3_r + kbs_pkg::TWO_PI_Q13;
    end else if (hm3_r >= kbs_pkg::TWO_PI_Q13) begin
      hm = hm3_r - kbs_pkg::TWO_PI_Q13;
    end else begin
      hm = hm3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hu1_r <= kbs_pkg::PI_Q13 - (32'(itm_r[S_DV].hd) + dh);
      hp2_r <= 58'(hu1_r) * $signed({33'b0, kbs_pkg::HD_RECIP});
      hu2_r <= hu1_r;
      hm3_r <= hu2_r - 32'(hq0) * kbs_pkg::TWO_PI_Q13;
      hd4_r <= 16'(kbs_pkg::PI_Q13 - hm);
    end
  end

  assign out_tvalid = vld_r[LAST];
  assign out_tdata  = {itm_r[LAST].v, hd4_r, ny_r[LAST], nx_r[LAST]};

endmodule
